>>> rtl/core/dmsc_pkg.sv
// ----------------------------------------------------------------------------
// dmsc_pkg
// Shared types and constants of the DNS message statistics counter bank.
// ----------------------------------------------------------------------------
package dmsc_pkg;

    localparam int NUM_COUNTERS = 40;
    localparam int CNT_IDX_W    = $clog2(NUM_COUNTERS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int C_REQ_V4         = 0;
    localparam int C_REQ_V6         = 1;
    localparam int C_REQ_EDNS0      = 2;
    localparam int C_REQ_BADEDNSVER = 3;
    localparam int C_REQ_TSIG       = 4;
    localparam int C_REQ_BADSIG     = 6;
    localparam int C_REQ_UDP        = 7;
    localparam int C_REQ_TCP        = 8;
    localparam int C_REQ_DO         = 9;
    localparam int C_OP_QUERY       = 10;
    localparam int C_OP_IQUERY      = 11;
    localparam int C_OP_STATUS      = 12;
    localparam int C_OP_NOTIFY      = 13;
    localparam int C_OP_UPDATE      = 14;
    localparam int C_OP_OTHER       = 15;
    localparam int C_RESPONSES      = 16;
    localparam int C_RESP_TC        = 17;
    localparam int C_RESP_EDNS0     = 18;
    localparam int C_RESP_TSIG      = 19;
    localparam int C_QRY_SUCCESS    = 21;
    localparam int C_QRY_AUTHANS    = 22;
    localparam int C_QRY_NOAUTHANS  = 23;
    localparam int C_QRY_REFERRAL   = 24;
    localparam int C_QRY_NXRRSET    = 25;
    localparam int C_QRY_REJECT     = 26;
    localparam int C_RCODE_BASE     = 27;
    localparam int C_RCODE_BADVERS  = 38;
    localparam int C_RCODE_OTHER    = 39;

    localparam logic [4:0]  OPCODE_NONE   = 5'd16;
    localparam logic [3:0]  OPCODE_QUERY  = 4'd0;
    localparam logic [11:0] RCODE_NOERROR = 12'd0;
    localparam logic [11:0] RCODE_REFUSED = 12'd5;
    localparam logic [11:0] RCODE_LAST    = 12'd10;
    localparam logic [11:0] RCODE_BADVERS = 12'd16;

    localparam logic [1:0] FAMILY_V4 = 2'd1;
    localparam logic [1:0] FAMILY_V6 = 2'd2;
    localparam logic [1:0] TRANS_UDP = 2'd1;
    localparam logic [1:0] TRANS_TCP = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_OPCODE = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef struct packed {
        logic                    is_read;
        logic [CNT_IDX_W-1:0]    index;
        status_t                 status;
        logic [NUM_COUNTERS-1:0] inc_mask;
    } entry_t;

    function automatic logic [CNT_IDX_W-1:0] op_class(input logic [3:0] op);
        logic [CNT_IDX_W-1:0] idx;
        unique case (op)
            4'd0:    idx = CNT_IDX_W'(C_OP_QUERY);
            4'd1:    idx = CNT_IDX_W'(C_OP_IQUERY);
            4'd2:    idx = CNT_IDX_W'(C_OP_STATUS);
            4'd4:    idx = CNT_IDX_W'(C_OP_NOTIFY);
            4'd5:    idx = CNT_IDX_W'(C_OP_UPDATE);
            default: idx = CNT_IDX_W'(C_OP_OTHER);
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/core/dmsc_in_if.sv
// ----------------------------------------------------------------------------
// dmsc_in_if
// Input channel: count or read items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmsc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  counter_index;
    logic [1:0]  ip_family;
    logic [1:0]  transport;
    logic [4:0]  opcode;
    logic [3:0]  request_flags;
    logic        responded;
    logic [4:0]  response_flags;
    logic [15:0] answer_count;
    logic [11:0] response_rcode;

    modport source (
        output valid, action, counter_index, ip_family, transport, opcode,
               request_flags, responded, response_flags, answer_count,
               response_rcode,
        input  ready
    );

    modport sink (
        input  valid, action, counter_index, ip_family, transport, opcode,
               request_flags, responded, response_flags, answer_count,
               response_rcode,
        output ready
    );
endinterface

>>> rtl/core/dmsc_out_if.sv
// ----------------------------------------------------------------------------
// dmsc_out_if
// Output channel: one status and read value per item.
// ----------------------------------------------------------------------------
interface dmsc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;

    modport source (
        output valid, status, read_value,
        input  ready
    );

    modport sink (
        input  valid, status, read_value,
        output ready
    );
endinterface

>>> rtl/core/dmsc_front.sv
// ----------------------------------------------------------------------------
// dmsc_front
// Accepts items and turns each count item into a counter increment mask.
// ----------------------------------------------------------------------------
module dmsc_front (
    dmsc_in_if.sink          in_ch,
    input  logic             push_ready,
    output logic             push_valid,
    output dmsc_pkg::entry_t push_entry
);
    import dmsc_pkg::*;

    logic                    has_op;
    logic                    badsig;
    logic                    aa;
    logic [NUM_COUNTERS-1:0] mask;
    logic [CNT_IDX_W-1:0]    rc_idx;

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;

    assign has_op = in_ch.opcode < OPCODE_NONE;
    assign badsig = in_ch.request_flags[1];
    assign aa     = in_ch.response_flags[3];
    assign rc_idx = CNT_IDX_W'(C_RCODE_BASE) + CNT_IDX_W'(in_ch.response_rcode[3:0]);

    always_comb
    begin
        mask = '0;
        if (in_ch.ip_family == FAMILY_V4)
        begin
            mask[C_REQ_V4] = 1'b1;
        end
        else if (in_ch.ip_family == FAMILY_V6)
        begin
            mask[C_REQ_V6] = 1'b1;
        end
        if (in_ch.transport == TRANS_UDP)
        begin
            mask[C_REQ_UDP] = 1'b1;
        end
        else if (in_ch.transport == TRANS_TCP)
        begin
            mask[C_REQ_TCP] = 1'b1;
        end
        if (has_op)
        begin
            mask[op_class(in_ch.opcode[3:0])] = 1'b1;
        end
        mask[C_REQ_TSIG] = in_ch.request_flags[0];
        if (badsig)
        begin
            mask[C_REQ_BADSIG] = 1'b1;
        end
        else
        begin
            mask[C_REQ_EDNS0] = in_ch.request_flags[2];
            mask[C_REQ_DO]    = in_ch.request_flags[3];
        end
        if (in_ch.responded)
        begin
            mask[C_RESPONSES]  = 1'b1;
            mask[C_RESP_TC]    = in_ch.response_flags[0];
            mask[C_RESP_EDNS0] = in_ch.response_flags[1];
            mask[C_RESP_TSIG]  = in_ch.response_flags[2];
            priority if (in_ch.response_rcode <= RCODE_LAST)
            begin
                mask[rc_idx] = 1'b1;
            end
            else if (in_ch.response_rcode == RCODE_BADVERS)
            begin
                mask[C_RCODE_BADVERS]  = 1'b1;
                mask[C_REQ_BADEDNSVER] = 1'b1;
            end
            else
            begin
                mask[C_RCODE_OTHER] = 1'b1;
            end
            if (has_op && !badsig && in_ch.opcode[3:0] == OPCODE_QUERY)
            begin
                if (aa)
                begin
                    mask[C_QRY_AUTHANS] = 1'b1;
                end
                else
                begin
                    mask[C_QRY_NOAUTHANS] = 1'b1;
                end
                if (in_ch.response_rcode == RCODE_NOERROR)
                begin
                    if (in_ch.answer_count != 16'd0)
                    begin
                        mask[C_QRY_SUCCESS] = 1'b1;
                    end
                    else if (aa)
                    begin
                        mask[C_QRY_NXRRSET] = 1'b1;
                    end
                    else
                    begin
                        mask[C_QRY_REFERRAL] = 1'b1;
                    end
                end
                else if (in_ch.response_rcode == RCODE_REFUSED)
                begin
                    mask[C_QRY_REJECT] = !in_ch.response_flags[4];
                end
            end
        end
    end

    always_comb
    begin
        push_entry.is_read = in_ch.action;
        push_entry.index   = in_ch.counter_index;
        if (in_ch.action)
        begin
            push_entry.inc_mask = '0;
            push_entry.status   = (in_ch.counter_index < CNT_IDX_W'(NUM_COUNTERS))
                                  ? STATUS_OK : STATUS_BAD_INDEX;
        end
        else
        begin
            push_entry.inc_mask = mask;
            push_entry.status   = (in_ch.responded && !has_op) ? STATUS_NO_OPCODE
                                                                : STATUS_OK;
        end
    end

endmodule

>>> rtl/core/dmsc_queue.sv
// ----------------------------------------------------------------------------
// dmsc_queue
// Short in-order queue between the classifier and the counter bank.
// ----------------------------------------------------------------------------
module dmsc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  dmsc_pkg::entry_t push_entry,
    output logic             push_ready,
    output logic             pop_valid,
    output dmsc_pkg::entry_t pop_entry,
    input  logic             pop
);
    import dmsc_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/dmsc_back.sv
// ----------------------------------------------------------------------------
// dmsc_back
// Counter bank: applies increment masks, serves reads, holds the result.
// ----------------------------------------------------------------------------
module dmsc_back #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  dmsc_pkg::entry_t q_entry,
    output logic             q_pop,
    dmsc_out_if.source       out_ch
);
    import dmsc_pkg::*;

    logic [COUNTER_WIDTH-1:0] cnt_reg [NUM_COUNTERS];
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg;
    logic [31:0]              read_value_reg;
    logic [63:0]              rd_wide;
    logic                     rd_ok;

    assign q_pop = q_valid && (!out_valid_reg || out_ch.ready);
    assign rd_ok = q_entry.is_read && (q_entry.status == STATUS_OK);
    assign rd_wide = rd_ok ? 64'(cnt_reg[q_entry.index]) : 64'd0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg     <= q_entry.status;
            read_value_reg <= rd_wide[31:0];
        end
    end

    for (genvar i = 0; i < NUM_COUNTERS; i++)
    begin : g_cnt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[i] <= '0;
            end
            else if (q_pop && q_entry.inc_mask[i])
            begin
                cnt_reg[i] <= cnt_reg[i] + 1'b1;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.read_value = read_value_reg;

endmodule

>>> rtl/core/dns_message_stat_counters_top.sv
// ----------------------------------------------------------------------------
// dns_message_stat_counters_top
// DNS message statistics: 40 counters bumped by count items, read by reads.
// datapath: each result passes through the queue, then the bank's output register
// throughput: one item per cycle while the output channel takes results, every counter updates in parallel
// reset: clears all counters, empties the two-entry queue and clears the valid bit of the output register
// ----------------------------------------------------------------------------
module dns_message_stat_counters_top #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    dmsc_in_if.sink    in_ch,
    dmsc_out_if.source out_ch
);
    import dmsc_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   q_valid;
    entry_t q_entry;
    logic   q_pop;

    dmsc_front u_front (
        .in_ch      (in_ch),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    dmsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry),
        .pop        (q_pop)
    );

    dmsc_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

    a_transfer_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> q_valid)
        else $error("accepted transfer did not reach the queue");

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_ch.valid)
        else $error("queue pop did not load the output register");

    a_bad_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.status == STATUS_BAD_INDEX) |=> (out_ch.read_value == 32'd0))
        else $error("bad index read returned a nonzero value");

endmodule

>>> sim/dmsc_stat_checker.sv
// ----------------------------------------------------------------------------
// dmsc_stat_checker
// Watches both channels of the DNS statistics counter bank. Keeps its own
// copy of the 40 counters, works out the status and read value of every
// accepted transfer, and compares each returned result with the oldest one
// still due. Hands the mismatch count and the number of results still due
// to the testbench top.
// ----------------------------------------------------------------------------
module dmsc_stat_checker (
    input  logic clk,
    input  logic rst_n,
    dmsc_in_if   in_mon,
    dmsc_out_if  out_mon,
    output int   fail_count,
    output int   pending,
    output int   compared
);
    timeunit 1ns;
    timeprecision 1ps;

    import dmsc_pkg::*;

    // request flag bits
    localparam int RQF_TSIG   = 0;
    localparam int RQF_BADSIG = 1;
    localparam int RQF_EDNS0  = 2;
    localparam int RQF_DO     = 3;

    // response flag bits
    localparam int RSF_TC    = 0;
    localparam int RSF_EDNS0 = 1;
    localparam int RSF_TSIG  = 2;
    localparam int RSF_AA    = 3;
    localparam int RSF_RD    = 4;

    // opcodes with a counter of their own
    localparam logic [3:0] OPC_IQUERY = 4'd1;
    localparam logic [3:0] OPC_STATUS = 4'd2;
    localparam logic [3:0] OPC_NOTIFY = 4'd4;
    localparam logic [3:0] OPC_UPDATE = 4'd5;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_value;
    } stat_result_t;

    logic [31:0]  stat_bank [NUM_COUNTERS];
    stat_result_t results_due [$];
    int           errors;
    int           checked;

    initial
    begin
        for (int i = 0; i < NUM_COUNTERS; i++)
            stat_bank[i] = '0;
        errors   = 0;
        checked  = 0;
    end

    task automatic report(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void bump_stat(input int idx);
        stat_bank[idx] = stat_bank[idx] + 32'd1;
    endfunction

    function automatic stat_result_t tally_item(
        input logic        is_read,
        input logic [5:0]  idx,
        input logic [1:0]  family,
        input logic [1:0]  transport,
        input logic [4:0]  opcode,
        input logic [3:0]  rqf,
        input logic        responded,
        input logic [4:0]  rsf,
        input logic [15:0] answers,
        input logic [11:0] rcode
    );
        stat_result_t r;
        logic         has_op;
        logic         badsig;
        logic         aa;
        r.status     = STATUS_OK;
        r.read_value = '0;
        has_op = opcode < OPCODE_NONE;
        badsig = rqf[RQF_BADSIG];
        aa     = rsf[RSF_AA];

        if (is_read)
        begin
            if (idx < NUM_COUNTERS)
                r.read_value = stat_bank[idx];
            else
                r.status = STATUS_BAD_INDEX;
            return r;
        end

        if (family == FAMILY_V4)
            bump_stat(C_REQ_V4);
        else if (family == FAMILY_V6)
            bump_stat(C_REQ_V6);
        if (transport == TRANS_UDP)
            bump_stat(C_REQ_UDP);
        else if (transport == TRANS_TCP)
            bump_stat(C_REQ_TCP);

        if (has_op)
        begin
            case (opcode[3:0])
                OPCODE_QUERY: bump_stat(C_OP_QUERY);
                OPC_IQUERY:   bump_stat(C_OP_IQUERY);
                OPC_STATUS:   bump_stat(C_OP_STATUS);
                OPC_NOTIFY:   bump_stat(C_OP_NOTIFY);
                OPC_UPDATE:   bump_stat(C_OP_UPDATE);
                default:      bump_stat(C_OP_OTHER);
            endcase
        end

        if (rqf[RQF_TSIG])
            bump_stat(C_REQ_TSIG);
        if (badsig)
            bump_stat(C_REQ_BADSIG);
        else
        begin
            if (rqf[RQF_EDNS0])
                bump_stat(C_REQ_EDNS0);
            if (rqf[RQF_DO])
                bump_stat(C_REQ_DO);
        end

        if (responded)
        begin
            bump_stat(C_RESPONSES);
            if (rsf[RSF_TC])
                bump_stat(C_RESP_TC);
            if (rsf[RSF_EDNS0])
                bump_stat(C_RESP_EDNS0);
            if (rsf[RSF_TSIG])
                bump_stat(C_RESP_TSIG);

            if (rcode <= RCODE_LAST)
                bump_stat(C_RCODE_BASE + int'(rcode));
            else if (rcode == RCODE_BADVERS)
                bump_stat(C_RCODE_BADVERS);
            else
                bump_stat(C_RCODE_OTHER);
            if (rcode == RCODE_BADVERS)
                bump_stat(C_REQ_BADEDNSVER);

            if (!has_op)
                r.status = STATUS_NO_OPCODE;
            else if (!badsig && opcode[3:0] == OPCODE_QUERY)
            begin
                bump_stat(aa ? C_QRY_AUTHANS : C_QRY_NOAUTHANS);
                if (rcode == RCODE_NOERROR)
                begin
                    if (answers != 16'd0)
                        bump_stat(C_QRY_SUCCESS);
                    else
                        bump_stat(aa ? C_QRY_NXRRSET : C_QRY_REFERRAL);
                end
                else if (rcode == RCODE_REFUSED && !rsf[RSF_RD])
                    bump_stat(C_QRY_REJECT);
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        stat_result_t due;
        if (rst_n)
        begin
            if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
                results_due.push_back(tally_item(in_mon.action, in_mon.counter_index,
                    in_mon.ip_family, in_mon.transport, in_mon.opcode,
                    in_mon.request_flags, in_mon.responded, in_mon.response_flags,
                    in_mon.answer_count, in_mon.response_rcode));

            if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
            begin
                if (results_due.size() == 0)
                    report("result transfer with nothing expected");
                else
                begin
                    due = results_due.pop_front();
                    checked++;
                    if (out_mon.status !== due.status)
                        report($sformatf("result %0d status %0d, expected %0d",
                            checked, out_mon.status, due.status));
                    if (out_mon.read_value !== due.read_value)
                        report($sformatf("result %0d read_value 0x%08h, expected 0x%08h",
                            checked, out_mon.read_value, due.read_value));
                end
            end
        end
        fail_count <= errors;
        pending    <= results_due.size();
        compared   <= checked;
    end

endmodule

>>> sim/tb_dns_message_stat_counters_top.sv
// ----------------------------------------------------------------------------
// tb_dns_message_stat_counters_top
// Drives count and read transfers into the DNS statistics counter bank:
// a short directed set over opcodes, rcode classes, flag extremes, missing
// opcodes and bad indexes, then random traffic with random gaps and output
// stalls, including one long output hold-off. The checker does the compare.
// ----------------------------------------------------------------------------
module tb_dns_message_stat_counters_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmsc_pkg::*;

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam int RANDOM_ITEMS = 1250;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic        action;
        logic [5:0]  counter_index;
        logic [1:0]  ip_family;
        logic [1:0]  transport;
        logic [4:0]  opcode;
        logic [3:0]  request_flags;
        logic        responded;
        logic [4:0]  response_flags;
        logic [15:0] answer_count;
        logic [11:0] response_rcode;
    } msg_item_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   compared;
    int   sent;
    int   counts_sent;
    int   no_opcode_sent;
    int   reads_sent;
    int   bad_reads_sent;
    int   cycles;

    dmsc_in_if  in_ch ();
    dmsc_out_if out_ch ();

    dns_message_stat_counters_top #(
        .COUNTER_WIDTH(32)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    dmsc_stat_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .compared   (compared)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic msg_item_t count_msg(
        input logic [1:0]  family,
        input logic [1:0]  transport,
        input logic [4:0]  opcode,
        input logic [3:0]  rqf,
        input logic        responded,
        input logic [4:0]  rsf,
        input logic [15:0] answers,
        input logic [11:0] rcode
    );
        msg_item_t m;
        m.action         = ACT_COUNT;
        m.counter_index  = 6'($urandom_range(0, 63));
        m.ip_family      = family;
        m.transport      = transport;
        m.opcode         = opcode;
        m.request_flags  = rqf;
        m.responded      = responded;
        m.response_flags = rsf;
        m.answer_count   = answers;
        m.response_rcode = rcode;
        return m;
    endfunction

    function automatic msg_item_t read_msg(input logic [5:0] idx);
        msg_item_t m;
        m = count_msg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
            5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
            1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
            16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)));
        m.action        = ACT_READ;
        m.counter_index = idx;
        return m;
    endfunction

    // random gaps except for a stretch in the middle of the random part
    task automatic offer(input msg_item_t m);
        while (!(sent >= 300 && sent < 550) && $urandom_range(0, 99) < 32)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= m.action;
        in_ch.counter_index  <= m.counter_index;
        in_ch.ip_family      <= m.ip_family;
        in_ch.transport      <= m.transport;
        in_ch.opcode         <= m.opcode;
        in_ch.request_flags  <= m.request_flags;
        in_ch.responded      <= m.responded;
        in_ch.response_flags <= m.response_flags;
        in_ch.answer_count   <= m.answer_count;
        in_ch.response_rcode <= m.response_rcode;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sent++;
        if (m.action == ACT_READ)
        begin
            reads_sent++;
            if (m.counter_index >= NUM_COUNTERS)
                bad_reads_sent++;
        end
        else
        begin
            counts_sent++;
            if (m.responded && m.opcode >= OPCODE_NONE)
                no_opcode_sent++;
        end
    endtask

    // output stalls, a calm window, and one long hold-off
    initial
    begin
        int cyc;
        cyc = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= 1500 && cyc < 1800)
                out_ch.ready <= 1'b0;
            else if (cyc >= 600 && cyc < 1000)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= 32);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, pending);
        $display("dns_message_stat_counters_top regression: fail");
        $finish;
    end

    initial
    begin
        msg_item_t   m;
        int          sel;
        logic [11:0] rc;
        sent           = 0;
        counts_sent    = 0;
        no_opcode_sent = 0;
        reads_sent     = 0;
        bad_reads_sent = 0;
        rst_n = 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.action         <= ACT_COUNT;
        in_ch.counter_index  <= '0;
        in_ch.ip_family      <= '0;
        in_ch.transport      <= '0;
        in_ch.opcode         <= '0;
        in_ch.request_flags  <= '0;
        in_ch.responded      <= 1'b0;
        in_ch.response_flags <= '0;
        in_ch.answer_count   <= '0;
        in_ch.response_rcode <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        offer(read_msg(6'd0));
        offer(count_msg(FAMILY_V4, TRANS_UDP, {1'b0, OPCODE_QUERY}, 4'hD, 1'b1, 5'h0A,
            16'd1, RCODE_NOERROR));
        offer(count_msg(FAMILY_V6, TRANS_TCP, {1'b0, OPCODE_QUERY}, 4'h0, 1'b1, 5'h08,
            16'd0, RCODE_NOERROR));
        offer(count_msg(2'd0, 2'd0, {1'b0, OPCODE_QUERY}, 4'h0, 1'b1, 5'h00,
            16'd0, RCODE_NOERROR));
        offer(count_msg(2'd3, 2'd3, {1'b0, OPCODE_QUERY}, 4'h0, 1'b1, 5'h00,
            16'd0, RCODE_REFUSED));
        offer(count_msg(FAMILY_V4, TRANS_UDP, {1'b0, OPCODE_QUERY}, 4'h0, 1'b1, 5'h10,
            16'd0, RCODE_REFUSED));
        offer(count_msg(FAMILY_V4, TRANS_UDP, {1'b0, OPCODE_QUERY}, 4'hF, 1'b1, 5'h1F,
            16'hFFFF, RCODE_BADVERS));
        offer(count_msg(FAMILY_V6, TRANS_TCP, OPCODE_NONE, 4'h0, 1'b1, 5'h07,
            16'd0, RCODE_LAST));
        offer(count_msg(FAMILY_V6, TRANS_TCP, 5'd31, 4'h0, 1'b1, 5'h00,
            16'd0, RCODE_LAST + 12'd1));
        offer(count_msg(FAMILY_V4, TRANS_UDP, OPCODE_NONE, 4'h0, 1'b0, 5'h00,
            16'd0, RCODE_NOERROR));
        offer(count_msg(FAMILY_V4, TRANS_UDP, {1'b0, OPCODE_QUERY}, 4'h0, 1'b1, 5'h00,
            16'd0, RCODE_BADVERS + 12'd1));
        offer(count_msg(FAMILY_V4, TRANS_UDP, {1'b0, OPCODE_QUERY}, 4'h0, 1'b1, 5'h00,
            16'd0, 12'hFFF));
        for (int op = 1; op < 16; op++)
            offer(count_msg(FAMILY_V4, TRANS_TCP, 5'(op), 4'h1, 1'b0, 5'h00,
                16'd0, RCODE_NOERROR));
        offer(read_msg(6'(C_OP_OTHER)));
        offer(read_msg(6'(C_RCODE_BADVERS)));
        offer(read_msg(6'(C_RCODE_OTHER)));
        offer(read_msg(6'(NUM_COUNTERS)));
        offer(read_msg(6'h3F));

        // random part: mostly count transfers with random content, reads in between
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
            begin
                if ($urandom_range(0, 9) == 0)
                    m = read_msg(6'($urandom_range(NUM_COUNTERS, 63)));
                else
                    m = read_msg(6'($urandom_range(0, NUM_COUNTERS - 1)));
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    rc = RCODE_NOERROR;
                else if (sel < 55)
                    rc = RCODE_REFUSED;
                else if (sel < 75)
                    rc = 12'($urandom_range(0, 16));
                else if (sel < 85)
                    rc = RCODE_BADVERS;
                else
                    rc = 12'($urandom_range(0, 4095));
                m = count_msg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    {1'b0, OPCODE_QUERY}, 4'($urandom_range(0, 15)),
                    ($urandom_range(0, 99) < 85), 5'($urandom_range(0, 31)),
                    16'($urandom_range(1, 65535)), rc);
                sel = $urandom_range(0, 99);
                if (sel >= 50 && sel < 85)
                    m.opcode = 5'($urandom_range(0, 15));
                else if (sel >= 85 && sel < 95)
                    m.opcode = OPCODE_NONE;
                else if (sel >= 95)
                    m.opcode = 5'($urandom_range(17, 31));
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    m.answer_count = 16'd0;
                else if (sel < 55)
                    m.answer_count = 16'hFFFF;
            end
            offer(m);
        end
        in_ch.valid <= 1'b0;

        // let the checker see the last transfer before polling its due count
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d count transfers (%0d responded without opcode)",
            counts_sent, no_opcode_sent);
        $display("and %0d reads (%0d out of range); %0d results compared in %0d cycles",
            reads_sent, bad_reads_sent, compared, cycles);
        if (fail_count == 0 && pending == 0)
            $display("dns_message_stat_counters_top regression: pass");
        else
            $display("dns_message_stat_counters_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dmsc_pkg.sv
rtl/core/dmsc_in_if.sv
rtl/core/dmsc_out_if.sv
rtl/core/dmsc_front.sv
rtl/core/dmsc_queue.sv
rtl/core/dmsc_back.sv
rtl/core/dns_message_stat_counters_top.sv
sim/dmsc_stat_checker.sv
sim/tb_dns_message_stat_counters_top.sv
